// ----- rtl/core/assert_macros.svh -----
// Assertion helper macros shared by the core RTL.
// Assumes a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLY(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPLY(lbl, pre, post)
`endif
`endif

// ----- rtl/core/mvna_pkg.sv -----
// Shared types, constants and width helpers for the vertex normal accumulator.
// No dependencies.
package mvna_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int COORD_BITS_DEF   = 16;
  localparam int SUM_BITS_DEF     = 24;

  localparam int VIDX_BITS = 10;   // width of every input vertex index field
  localparam int CCNT_BITS = 3;
  localparam int OUT_BITS  = 16;   // Q1.14 result width
  localparam int NRM_BITS  = 20;   // largest magnitude after scaling: [2^19, 2^20)
  localparam int LEN_BITS  = 21;
  localparam int L2_BITS   = 42;
  localparam int DIV_BITS  = 36;
  localparam int QUO_BITS  = 15;
  localparam int FRAC_SH   = 15;   // 2 * 16384

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_FACE = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  function automatic int cmd_bits(input int aw, input int cb);
    return 2 + 1 + 4 * aw + 3 * cb;
  endfunction

  function automatic int mag_bits(input int cb, input int sb);
    int w;
    w = 2 * cb + 3;
    if (sb > w) w = sb;
    if (w < NRM_BITS + 1) w = NRM_BITS + 1;
    return w;
  endfunction

endpackage

// ----- rtl/core/mesh_vertex_normal_accumulator.sv -----
// Mesh vertex normal accumulator, top level.
// Depends on mvna_pkg, mvna_front, mvna_queue, mvna_back.
//
// Input channel (in_valid/in_ready): one transaction per action. Load stores a
// position and clears the vertex sum; add-face adds the unit face normal to
// each of its 3 or 4 corners; read returns one Q1.14 normal on the output
// channel (out_valid/out_ready). Action code 3 is dropped.
// Configuration: cfg_we with cfg_wdata sets the output negate bit (reset 1),
// write only while idle.
// Timing: the back end does a load in its idle state. Read and face times are
// set by the iterative normalizer (shift scan, one square-root bit and one
// quotient bit per cycle), which stops early on a zero vector, and a face adds
// one sum read-modify-write per corner.
// A two-entry queue lets the front keep taking transactions while the back
// works. Memories need no clearing, since the user must load every vertex
// before use; the block itself does not enforce this. Reset (rst_n low,
// synchronous) empties the queue and drops any pending result. A stalled
// receiver holds the result register; the back end keeps running loads and
// faces and waits only when the next read result is ready.
module mesh_vertex_normal_accumulator import mvna_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int SUM_BITS     = SUM_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_action,
  input  logic [VIDX_BITS-1:0]        in_vertex_index,
  input  logic signed [COORD_BITS-1:0] in_pos_x,
  input  logic signed [COORD_BITS-1:0] in_pos_y,
  input  logic signed [COORD_BITS-1:0] in_pos_z,
  input  logic [VIDX_BITS-1:0]        in_corner_a,
  input  logic [VIDX_BITS-1:0]        in_corner_b,
  input  logic [VIDX_BITS-1:0]        in_corner_c,
  input  logic [VIDX_BITS-1:0]        in_corner_d,
  input  logic [CCNT_BITS-1:0]        in_corner_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [OUT_BITS-1:0]  out_normal_x,
  output logic signed [OUT_BITS-1:0]  out_normal_y,
  output logic signed [OUT_BITS-1:0]  out_normal_z,
  output logic                        out_degenerate
);

  localparam int CMD_W = cmd_bits($clog2(MAX_VERTICES), COORD_BITS);

  logic             flip_r, flip_nxt;
  logic             q_full, q_push, q_pop, q_valid;
  logic [CMD_W-1:0] q_wdata, q_rdata;

  assign flip_nxt = cfg_we ? cfg_wdata : flip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flip_r <= 1'b1;
    end else begin
      flip_r <= flip_nxt;
    end
  end

  mvna_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_vertex_index (in_vertex_index),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_corner_a     (in_corner_a),
    .in_corner_b     (in_corner_b),
    .in_corner_c     (in_corner_c),
    .in_corner_d     (in_corner_d),
    .in_corner_count (in_corner_count),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_wdata         (q_wdata)
  );

  mvna_queue #(.W(CMD_W)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  mvna_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS),
    .SUM_BITS     (SUM_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .flip      (flip_r),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_nx    (out_normal_x),
    .out_ny    (out_normal_y),
    .out_nz    (out_normal_z),
    .out_deg   (out_degenerate)
  );

endmodule

// ----- rtl/core/mvna_front.sv -----
// Front end: takes input transactions, reduces indices and classifies them.
// Depends on mvna_pkg; feeds mvna_queue.
module mvna_front import mvna_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_action,
  input  logic [VIDX_BITS-1:0]          in_vertex_index,
  input  logic signed [COORD_BITS-1:0]  in_pos_x,
  input  logic signed [COORD_BITS-1:0]  in_pos_y,
  input  logic signed [COORD_BITS-1:0]  in_pos_z,
  input  logic [VIDX_BITS-1:0]          in_corner_a,
  input  logic [VIDX_BITS-1:0]          in_corner_b,
  input  logic [VIDX_BITS-1:0]          in_corner_c,
  input  logic [VIDX_BITS-1:0]          in_corner_d,
  input  logic [CCNT_BITS-1:0]          in_corner_count,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [cmd_bits($clog2(MAX_VERTICES), COORD_BITS)-1:0] q_wdata
);

  localparam int AW = $clog2(MAX_VERTICES);

  typedef struct packed {
    action_t                      op;
    logic                         quad;
    logic [AW-1:0]                c0;
    logic [AW-1:0]                c1;
    logic [AW-1:0]                c2;
    logic [AW-1:0]                c3;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] pz;
  } cmd_t;

  // index modulo vertex count: compare-subtract against the count shifted left by 7 down to 0
  function automatic logic [AW-1:0] to_addr(input logic [VIDX_BITS-1:0] v);
    logic [VIDX_BITS-1:0]    r;
    longint                  mk;
    logic [AW+VIDX_BITS-1:0] ext;
    r = v;
    for (int k = 7; k >= 0; k--) begin
      mk = longint'(MAX_VERTICES) << k;
      if (longint'(r) >= mk) r = r - VIDX_BITS'(mk);
    end
    ext = {{AW{1'b0}}, r};
    return ext[AW-1:0];
  endfunction

  action_t act;
  cmd_t    cmd;

  always_comb begin
    act      = action_t'(in_action);
    cmd.op   = act;
    cmd.quad = (in_corner_count == CCNT_BITS'(4));
    cmd.c0   = (act == ACT_FACE) ? to_addr(in_corner_a) : to_addr(in_vertex_index);
    cmd.c1   = to_addr(in_corner_b);
    cmd.c2   = to_addr(in_corner_c);
    cmd.c3   = to_addr(in_corner_d);
    cmd.px   = in_pos_x;
    cmd.py   = in_pos_y;
    cmd.pz   = in_pos_z;
  end

  assign in_ready = !q_full;
  // drop unknown actions here
  assign q_push   = in_valid && !q_full && (act != ACT_NONE);
  assign q_wdata  = cmd;

endmodule

// ----- rtl/core/mvna_queue.sv -----
// Two-entry command queue between front and back end.
// Depends on mvna_pkg for the default width and on assert_macros.svh for assertions.
`include "assert_macros.svh"
module mvna_queue import mvna_pkg::*; #(
  parameter int W = cmd_bits($clog2(MAX_VERTICES_DEF), COORD_BITS_DEF)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] rdata
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (PW+1)'(DEPTH));
  assign valid = (cnt_r != '0);
  assign rdata = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  `ASSERT_ALWAYS(a_q_no_overflow, !(push && full) && !(pop && !valid))

endmodule

// ----- rtl/core/mvna_norm.sv -----
// Iterative Q1.14 normalizer: scale, sum of squares, bit-serial square root,
// restoring divide per component. Depends on mvna_pkg.
`include "assert_macros.svh"
module mvna_norm import mvna_pkg::*; #(
  parameter int MAG_W = mag_bits(COORD_BITS_DEF, SUM_BITS_DEF)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [MAG_W-1:0]    vin [3],
  output logic                       done,
  output logic signed [OUT_BITS-1:0] nout [3],
  output logic                       deg
);

  typedef enum logic [6:0] {
    N_IDLE  = 7'h01,
    N_SHIFT = 7'h02,
    N_SQ    = 7'h04,
    N_SQRT  = 7'h08,
    N_DLD   = 7'h10,
    N_DIV   = 7'h20,
    N_DONE  = 7'h40
  } nst_t;

  nst_t                      st_r, st_nxt;
  logic [MAG_W-1:0]          mag_r [3];
  logic [MAG_W-1:0]          mag_nxt [3];
  logic [2:0]                sgn_r, sgn_nxt;
  logic [3:0]                cnt_r, cnt_nxt;
  logic [1:0]                k_r, k_nxt;
  logic [2*NRM_BITS-1:0]     sq_r, sq_nxt;
  logic [L2_BITS-1:0]        l2_r, l2_nxt;
  logic [L2_BITS-1:0]        res_r, res_nxt;
  logic [L2_BITS-1:0]        bit_r, bit_nxt;
  logic [DIV_BITS-1:0]       rem_r, rem_nxt;
  logic [DIV_BITS-1:0]       ds_r, ds_nxt;
  logic [QUO_BITS-1:0]       quo_r, quo_nxt;
  logic signed [OUT_BITS-1:0] nout_r [3];
  logic signed [OUT_BITS-1:0] nout_nxt [3];
  logic                      deg_r, deg_nxt;

  logic                      any_hi, any_19, all_zero;
  logic [NRM_BITS-1:0]       msel;
  logic [LEN_BITS-1:0]       len;
  logic [L2_BITS-1:0]        trial;
  logic [QUO_BITS-1:0]       qn;

  assign done = (st_r == N_DONE);
  assign nout = nout_r;
  assign deg  = deg_r;

  always_comb begin
    any_hi   = 1'b0;
    any_19   = 1'b0;
    all_zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      any_hi   = any_hi | (|mag_r[i][MAG_W-1:NRM_BITS]);
      any_19   = any_19 | (|mag_r[i][MAG_W-1:NRM_BITS-1]);
      all_zero = all_zero & (mag_r[i] == '0);
    end
  end

  always_comb begin
    st_nxt  = st_r;
    mag_nxt = mag_r;
    sgn_nxt = sgn_r;
    cnt_nxt = cnt_r;
    k_nxt   = k_r;
    sq_nxt  = sq_r;
    l2_nxt  = l2_r;
    res_nxt = res_r;
    bit_nxt = bit_r;
    rem_nxt = rem_r;
    ds_nxt  = ds_r;
    quo_nxt = quo_r;
    nout_nxt = nout_r;
    deg_nxt = deg_r;
    msel    = mag_r[(cnt_r[1:0] == 2'd3) ? k_r : cnt_r[1:0]][NRM_BITS-1:0];
    len     = res_r[LEN_BITS-1:0];
    trial   = res_r + bit_r;
    qn      = '0;
    unique case (st_r)
      N_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            sgn_nxt[i] = vin[i][MAG_W-1];
            mag_nxt[i] = vin[i][MAG_W-1] ? MAG_W'(-vin[i]) : MAG_W'(vin[i]);
          end
          st_nxt = N_SHIFT;
        end
      end
      N_SHIFT: begin
        if (all_zero) begin
          for (int i = 0; i < 3; i++) nout_nxt[i] = '0;
          deg_nxt = 1'b1;
          st_nxt  = N_DONE;
        end else if (any_hi) begin
          for (int i = 0; i < 3; i++) mag_nxt[i] = mag_r[i] >> 1;
        end else if (!any_19) begin
          for (int i = 0; i < 3; i++) mag_nxt[i] = mag_r[i] << 1;
        end else begin
          deg_nxt = 1'b0;
          cnt_nxt = '0;
          l2_nxt  = '0;
          st_nxt  = N_SQ;
        end
      end
      N_SQ: begin
        // one square a cycle, each added to the sum in the following cycle
        if (cnt_r != 4'd3) sq_nxt = msel * msel;
        if (cnt_r != 4'd0) l2_nxt = l2_r + L2_BITS'(sq_r);
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd3) begin
          res_nxt = '0;
          bit_nxt = L2_BITS'(1) << (L2_BITS - 2);
          st_nxt  = N_SQRT;
        end
      end
      N_SQRT: begin
        if (bit_r == '0) begin
          k_nxt  = '0;
          st_nxt = N_DLD;
        end else begin
          if (l2_r >= trial) begin
            l2_nxt  = l2_r - trial;
            res_nxt = (res_r >> 1) + bit_r;
          end else begin
            res_nxt = res_r >> 1;
          end
          bit_nxt = bit_r >> 2;
        end
      end
      N_DLD: begin
        cnt_nxt = 4'd3;
        rem_nxt = DIV_BITS'({msel, {FRAC_SH{1'b0}}}) + DIV_BITS'(len);
        ds_nxt  = {len, {FRAC_SH{1'b0}}};
        quo_nxt = '0;
        st_nxt  = N_DIV;
      end
      N_DIV: begin
        // cnt holds 3 so msel keeps pointing at component k
        if (rem_r >= ds_r) begin
          rem_nxt = rem_r - ds_r;
          qn      = {quo_r[QUO_BITS-2:0], 1'b1};
        end else begin
          qn      = {quo_r[QUO_BITS-2:0], 1'b0};
        end
        quo_nxt = qn;
        ds_nxt  = ds_r >> 1;
        // last step divides by 2*len
        if (ds_r == DIV_BITS'({len, 1'b0})) begin
          nout_nxt[k_r] = sgn_r[k_r] ? -OUT_BITS'({1'b0, qn}) : OUT_BITS'({1'b0, qn});
          if (k_r == 2'd2) begin
            st_nxt = N_DONE;
          end else begin
            k_nxt  = k_r + 2'd1;
            st_nxt = N_DLD;
          end
        end
      end
      N_DONE: begin
        st_nxt = N_IDLE;
      end
      default: st_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= N_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    sgn_r  <= sgn_nxt;
    cnt_r  <= cnt_nxt;
    k_r    <= k_nxt;
    sq_r   <= sq_nxt;
    l2_r   <= l2_nxt;
    res_r  <= res_nxt;
    bit_r  <= bit_nxt;
    rem_r  <= rem_nxt;
    ds_r   <= ds_nxt;
    quo_r  <= quo_nxt;
    nout_r <= nout_nxt;
    deg_r  <= deg_nxt;
  end

  `ASSERT_ALWAYS(a_start_when_idle, !start || (st_r == N_IDLE))

endmodule

// ----- rtl/core/mvna_back.sv -----
// Back end: executes queued commands against the position and sum memories,
// drives the normalizer and holds the result register. Depends on mvna_pkg, mvna_norm.
`include "assert_macros.svh"
module mvna_back import mvna_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int SUM_BITS     = SUM_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       flip,
  input  logic                       q_valid,
  input  logic [cmd_bits($clog2(MAX_VERTICES), COORD_BITS)-1:0] q_rdata,
  output logic                       q_pop,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic signed [OUT_BITS-1:0] out_nx,
  output logic signed [OUT_BITS-1:0] out_ny,
  output logic signed [OUT_BITS-1:0] out_nz,
  output logic                       out_deg
);

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CB    = COORD_BITS;
  localparam int SB    = SUM_BITS;
  localparam int CRW   = 2 * CB + 3;
  localparam int MAG_W = mag_bits(COORD_BITS, SUM_BITS);

  typedef struct packed {
    action_t               op;
    logic                  quad;
    logic [AW-1:0]         c0;
    logic [AW-1:0]         c1;
    logic [AW-1:0]         c2;
    logic [AW-1:0]         c3;
    logic signed [CB-1:0]  px;
    logic signed [CB-1:0]  py;
    logic signed [CB-1:0]  pz;
  } cmd_t;

  typedef enum logic [10:0] {
    B_IDLE = 11'h001,
    F_RD   = 11'h002,
    F_DIFF = 11'h004,
    F_MUL  = 11'h008,
    F_NST  = 11'h010,
    F_NORM = 11'h020,
    F_SRD  = 11'h040,
    F_SWR  = 11'h080,
    R_WAIT = 11'h100,
    R_NORM = 11'h200,
    R_OUT  = 11'h400
  } bst_t;

  function automatic logic signed [SB-1:0] sat_add(input logic signed [SB-1:0] a,
                                                   input logic signed [OUT_BITS-1:0] b);
    logic signed [SB:0] s;
    s = {a[SB-1], a} + (SB+1)'(b);
    if (s[SB] != s[SB-1]) begin
      return s[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
    end
    return s[SB-1:0];
  endfunction

  logic [3*CB-1:0] pos_mem [MAX_VERTICES];
  logic [3*SB-1:0] sum_mem [MAX_VERTICES];

  logic            pos_we, pos_re, sum_we, sum_re;
  logic [AW-1:0]   pos_wa, pos_ra, sum_wa, sum_ra;
  logic [3*CB-1:0] pos_wd, pos_rd_q;
  logic [3*SB-1:0] sum_wd, sum_rd_q;

  bst_t                       st_r, st_nxt;
  cmd_t                       cmd_r, cmd_nxt, qcmd;
  logic [2:0]                 cnt_r, cnt_nxt;
  logic signed [CB-1:0]       p0_r [3], p1_r [3], pl_r [3];
  logic signed [CB-1:0]       p0_nxt [3], p1_nxt [3], pl_nxt [3];
  logic signed [CB:0]         e0_r [3], e1_r [3], e0_nxt [3], e1_nxt [3];
  logic signed [2*CB+1:0]     prod_r, prod_nxt;
  logic signed [CRW-1:0]      cr_r [3], cr_nxt [3];
  logic signed [OUT_BITS-1:0] nrm_r [3], nrm_nxt [3];
  logic                       deg_r, deg_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [OUT_BITS-1:0] onx_r, ony_r, onz_r, onx_nxt, ony_nxt, onz_nxt;
  logic                       odeg_r, odeg_nxt;

  logic signed [CB:0]         ma, mb;
  logic signed [CB-1:0]       prd [3];
  logic signed [SB-1:0]       srd [3];
  logic [AW-1:0]              corner;
  logic [AW-1:0]              last_c;

  logic                       nm_start, nm_done, nm_deg;
  logic signed [MAG_W-1:0]    nm_v [3];
  logic signed [OUT_BITS-1:0] nm_n [3];

  mvna_norm #(.MAG_W(MAG_W)) u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (nm_start),
    .vin   (nm_v),
    .done  (nm_done),
    .nout  (nm_n),
    .deg   (nm_deg)
  );

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    if (pos_re) pos_rd_q <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    if (sum_re) sum_rd_q <= sum_mem[sum_ra];
  end

  assign qcmd      = cmd_t'(q_rdata);
  assign out_valid = out_valid_r;
  assign out_nx    = onx_r;
  assign out_ny    = ony_r;
  assign out_nz    = onz_r;
  assign out_deg   = odeg_r;

  always_comb begin
    prd[0] = pos_rd_q[3*CB-1:2*CB];
    prd[1] = pos_rd_q[2*CB-1:CB];
    prd[2] = pos_rd_q[CB-1:0];
    srd[0] = sum_rd_q[3*SB-1:2*SB];
    srd[1] = sum_rd_q[2*SB-1:SB];
    srd[2] = sum_rd_q[SB-1:0];
    last_c = cmd_r.quad ? cmd_r.c3 : cmd_r.c2;
    unique case (cnt_r[1:0])
      2'd0:    corner = cmd_r.c0;
      2'd1:    corner = cmd_r.c1;
      2'd2:    corner = cmd_r.c2;
      default: corner = cmd_r.c3;
    endcase
    unique case (cnt_r)
      3'd0:    begin ma = e0_r[1]; mb = e1_r[2]; end
      3'd1:    begin ma = e0_r[2]; mb = e1_r[1]; end
      3'd2:    begin ma = e0_r[2]; mb = e1_r[0]; end
      3'd3:    begin ma = e0_r[0]; mb = e1_r[2]; end
      3'd4:    begin ma = e0_r[0]; mb = e1_r[1]; end
      3'd5:    begin ma = e0_r[1]; mb = e1_r[0]; end
      default: begin ma = '0;      mb = '0;      end
    endcase
  end

  always_comb begin
    st_nxt        = st_r;
    cmd_nxt       = cmd_r;
    cnt_nxt       = cnt_r;
    p0_nxt        = p0_r;
    p1_nxt        = p1_r;
    pl_nxt        = pl_r;
    e0_nxt        = e0_r;
    e1_nxt        = e1_r;
    prod_nxt      = prod_r;
    cr_nxt        = cr_r;
    nrm_nxt       = nrm_r;
    deg_nxt       = deg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    onx_nxt       = onx_r;
    ony_nxt       = ony_r;
    onz_nxt       = onz_r;
    odeg_nxt      = odeg_r;
    q_pop         = 1'b0;
    pos_we        = 1'b0;
    pos_wa        = qcmd.c0;
    pos_wd        = {qcmd.px, qcmd.py, qcmd.pz};
    pos_re        = 1'b0;
    pos_ra        = cmd_r.c0;
    sum_we        = 1'b0;
    sum_wa        = qcmd.c0;
    sum_wd        = '0;
    sum_re        = 1'b0;
    sum_ra        = qcmd.c0;
    nm_start      = 1'b0;
    for (int i = 0; i < 3; i++) nm_v[i] = MAG_W'(srd[i]);
    unique case (st_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = qcmd;
          cnt_nxt = '0;
          unique case (qcmd.op)
            ACT_LOAD: begin
              pos_we = 1'b1;
              sum_we = 1'b1;
            end
            ACT_FACE: st_nxt = F_RD;
            ACT_READ: begin
              sum_re = 1'b1;
              st_nxt = R_WAIT;
            end
            default: st_nxt = B_IDLE;
          endcase
        end
      end
      F_RD: begin
        // issue corner 0, corner 1, last corner; data lands in the following cycle
        pos_re = (cnt_r != 3'd3);
        unique case (cnt_r[1:0])
          2'd0:    pos_ra = cmd_r.c0;
          2'd1:    pos_ra = cmd_r.c1;
          default: pos_ra = last_c;
        endcase
        if (cnt_r == 3'd1) p0_nxt = prd;
        if (cnt_r == 3'd2) p1_nxt = prd;
        if (cnt_r == 3'd3) begin
          pl_nxt = prd;
          st_nxt = F_DIFF;
        end
        cnt_nxt = cnt_r + 3'd1;
      end
      F_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          e0_nxt[i] = (CB+1)'(pl_r[i]) - (CB+1)'(p0_r[i]);
          e1_nxt[i] = (CB+1)'(p1_r[i]) - (CB+1)'(p0_r[i]);
        end
        cnt_nxt = '0;
        st_nxt  = F_MUL;
      end
      F_MUL: begin
        // product of pair n is folded in on the following cycle
        prod_nxt = ma * mb;
        unique case (cnt_r)
          3'd1:    cr_nxt[0] = CRW'(prod_r);
          3'd2:    cr_nxt[0] = cr_r[0] - CRW'(prod_r);
          3'd3:    cr_nxt[1] = CRW'(prod_r);
          3'd4:    cr_nxt[1] = cr_r[1] - CRW'(prod_r);
          3'd5:    cr_nxt[2] = CRW'(prod_r);
          3'd6:    cr_nxt[2] = cr_r[2] - CRW'(prod_r);
          default: cr_nxt = cr_r;
        endcase
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd6) st_nxt = F_NST;
      end
      F_NST: begin
        nm_start = 1'b1;
        for (int i = 0; i < 3; i++) nm_v[i] = MAG_W'(cr_r[i]);
        st_nxt = F_NORM;
      end
      F_NORM: begin
        if (nm_done) begin
          nrm_nxt = nm_n;
          cnt_nxt = '0;
          st_nxt  = F_SRD;
        end
      end
      F_SRD: begin
        sum_re = 1'b1;
        sum_ra = corner;
        st_nxt = F_SWR;
      end
      F_SWR: begin
        sum_we = 1'b1;
        sum_wa = corner;
        sum_wd = {sat_add(srd[0], nrm_r[0]), sat_add(srd[1], nrm_r[1]),
                  sat_add(srd[2], nrm_r[2])};
        if (cnt_r[1:0] == (cmd_r.quad ? 2'd3 : 2'd2)) begin
          st_nxt = B_IDLE;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
          st_nxt  = F_SRD;
        end
      end
      R_WAIT: begin
        nm_start = 1'b1;
        st_nxt   = R_NORM;
      end
      R_NORM: begin
        if (nm_done) begin
          for (int i = 0; i < 3; i++) nrm_nxt[i] = flip ? -nm_n[i] : nm_n[i];
          deg_nxt = nm_deg;
          st_nxt  = R_OUT;
        end
      end
      R_OUT: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          onx_nxt       = nrm_r[0];
          ony_nxt       = nrm_r[1];
          onz_nxt       = nrm_r[2];
          odeg_nxt      = deg_r;
          st_nxt        = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    cnt_r  <= cnt_nxt;
    p0_r   <= p0_nxt;
    p1_r   <= p1_nxt;
    pl_r   <= pl_nxt;
    e0_r   <= e0_nxt;
    e1_r   <= e1_nxt;
    prod_r <= prod_nxt;
    cr_r   <= cr_nxt;
    nrm_r  <= nrm_nxt;
    deg_r  <= deg_nxt;
    onx_r  <= onx_nxt;
    ony_r  <= ony_nxt;
    onz_r  <= onz_nxt;
    odeg_r <= odeg_nxt;
  end

  `ASSERT_ALWAYS(a_done_while_waiting, !nm_done || (st_r == F_NORM) || (st_r == R_NORM))
  `ASSERT_IMPLY(a_rmw_order, st_r == F_SWR, $past(st_r) == F_SRD)

endmodule

// ----- verif/mesh_vertex_normal_accumulator_test.sv -----
// Self-checking testbench for mesh_vertex_normal_accumulator.
// Depends on mvna_pkg and the RTL. A directed table, a saturation run, then random traffic;
// reads are checked against a fixed-point predictor here or, in typed rows, stated values.
module mesh_vertex_normal_accumulator_test;
  import mvna_pkg::*;

  localparam int NV       = 1024;
  localparam longint SMAX = (64'sd1 <<< 23) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam int HOLD_CYC = 400;
  localparam int DRAIN    = 600;
  localparam int WDOG_LIM = 20000;

  typedef struct {
    action_t            act;
    logic [9:0]         vidx;
    logic signed [15:0] px, py, pz;
    logic [9:0]         ca, cb, cc, cd;
    logic [2:0]         cnt;
    bit                 typed;
    logic signed [15:0] ex, ey, ez;
    bit                 edeg;
  } mesh_cmd_t;

  typedef struct {
    logic signed [15:0] x, y, z;
    bit                 deg;
  } normal_t;

  logic clk, rst_n;
  logic cfg_we = 1'b0, cfg_wdata = 1'b0;
  logic in_valid = 1'b0, in_ready;
  logic [1:0] in_action = '0;
  logic [9:0] in_vertex_index = '0;
  logic signed [15:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [9:0] in_corner_a = '0, in_corner_b = '0, in_corner_c = '0, in_corner_d = '0;
  logic [2:0] in_corner_count = '0;
  logic out_valid, out_ready = 1'b1;
  logic signed [15:0] out_normal_x, out_normal_y, out_normal_z;
  logic out_degenerate;

  mesh_vertex_normal_accumulator u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_vertex_index(in_vertex_index), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_pos_z(in_pos_z), .in_corner_a(in_corner_a), .in_corner_b(in_corner_b),
    .in_corner_c(in_corner_c), .in_corner_d(in_corner_d),
    .in_corner_count(in_corner_count), .out_valid(out_valid), .out_ready(out_ready),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z), .out_degenerate(out_degenerate)
  );

  // predictor state
  logic signed [15:0] vert_pos[NV][3];
  longint             vert_sum[NV][3];
  bit                 flip_q;
  bit                 loaded[NV];
  int                 loaded_ids[$];
  normal_t            pending_normals[$];

  int  mismatches = 0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;
  int  quiet_cycles = 0;
  mesh_cmd_t dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned root64(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic normal_t unit_q14(input longint vx, input longint vy, input longint vz);
    longint v[3];
    longint unsigned mag[3];
    longint unsigned mx, l2, len, q;
    logic signed [15:0] o[3];
    normal_t r;
    v[0] = vx; v[1] = vy; v[2] = vz;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) begin
      r = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
      return r;
    end
    // bring the largest magnitude into [2^19, 2^20)
    while (mx < (64'd1 << 19)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    while (mx >= (64'd1 << 20)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    l2 = 0;
    for (int i = 0; i < 3; i++) l2 += mag[i] * mag[i];
    len = root64(l2);
    for (int i = 0; i < 3; i++) begin
      q = (2 * mag[i] * 16384 + len) / (2 * len);
      o[i] = v[i] < 0 ? -16'(q) : 16'(q);
    end
    r = '{o[0], o[1], o[2], 1'b0};
    return r;
  endfunction

  function automatic longint sat_sum(input longint a, input longint b);
    longint s;
    s = a + b;
    if (s > SMAX) return SMAX;
    if (s < SMIN) return SMIN;
    return s;
  endfunction

  // advance the predictor by one accepted transaction
  task automatic apply_cmd(input mesh_cmd_t c);
    int n;
    int cn[4];
    longint e0[3], e1[3], p0;
    normal_t nf, nr;
    case (c.act)
      ACT_LOAD: begin
        vert_pos[c.vidx][0] = c.px;
        vert_pos[c.vidx][1] = c.py;
        vert_pos[c.vidx][2] = c.pz;
        for (int i = 0; i < 3; i++) vert_sum[c.vidx][i] = 0;
        if (!loaded[c.vidx]) begin
          loaded[c.vidx] = 1'b1;
          loaded_ids.insert(loaded_ids.size(), c.vidx);
        end
      end
      ACT_FACE: begin
        n = (c.cnt == 3'd4) ? 4 : 3;
        cn[0] = c.ca; cn[1] = c.cb; cn[2] = c.cc; cn[3] = c.cd;
        for (int i = 0; i < 3; i++) begin
          p0 = vert_pos[cn[0]][i];
          e0[i] = longint'(vert_pos[cn[n-1]][i]) - p0;
          e1[i] = longint'(vert_pos[cn[1]][i]) - p0;
        end
        nf = unit_q14(e0[1] * e1[2] - e0[2] * e1[1], e0[2] * e1[0] - e0[0] * e1[2],
                      e0[0] * e1[1] - e0[1] * e1[0]);
        for (int k = 0; k < n; k++) begin
          vert_sum[cn[k]][0] = sat_sum(vert_sum[cn[k]][0], nf.x);
          vert_sum[cn[k]][1] = sat_sum(vert_sum[cn[k]][1], nf.y);
          vert_sum[cn[k]][2] = sat_sum(vert_sum[cn[k]][2], nf.z);
        end
      end
      ACT_READ: begin
        nr = unit_q14(vert_sum[c.vidx][0], vert_sum[c.vidx][1], vert_sum[c.vidx][2]);
        if (flip_q) begin
          nr.x = -nr.x; nr.y = -nr.y; nr.z = -nr.z;
        end
        if (c.typed) nr = '{c.ex, c.ey, c.ez, c.edeg};
        pending_normals.insert(pending_normals.size(), nr);
      end
      default: ;  // unknown action: drop
    endcase
  endtask

  task automatic send_cmd(input mesh_cmd_t c);
    in_valid <= 1'b1;
    in_action <= c.act;
    in_vertex_index <= c.vidx;
    in_pos_x <= c.px; in_pos_y <= c.py; in_pos_z <= c.pz;
    in_corner_a <= c.ca; in_corner_b <= c.cb; in_corner_c <= c.cc; in_corner_d <= c.cd;
    in_corner_count <= c.cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_cmd(c);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  function automatic mesh_cmd_t noise_cmd(input action_t a);
    mesh_cmd_t c;
    c.act = a;
    c.vidx = 10'($urandom);
    c.px = 16'($urandom); c.py = 16'($urandom); c.pz = 16'($urandom);
    c.ca = 10'($urandom); c.cb = 10'($urandom); c.cc = 10'($urandom); c.cd = 10'($urandom);
    c.cnt = 3'($urandom);
    c.typed = 1'b0;
    c.ex = '0; c.ey = '0; c.ez = '0; c.edeg = 1'b0;
    return c;
  endfunction

  function automatic mesh_cmd_t mk_cmd(input action_t a, input int vi, input int x,
                                       input int y, input int z, input int ka, input int kb,
                                       input int kc, input int kd, input int cnt);
    mesh_cmd_t c;
    c = noise_cmd(a);
    c.vidx = 10'(vi);
    c.px = 16'(x); c.py = 16'(y); c.pz = 16'(z);
    c.ca = 10'(ka); c.cb = 10'(kb); c.cc = 10'(kc); c.cd = 10'(kd);
    c.cnt = 3'(cnt);
    return c;
  endfunction

  function automatic int pick_loaded();
    return loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
  endfunction

  task automatic drain_and_idle();
    in_valid <= 1'b0;
    while (pending_normals.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_flip(input bit v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    flip_q = v;
  endtask

  // append one row to the directed table
  task automatic add_row(input mesh_cmd_t c);
    dir_rows.insert(dir_rows.size(), c);
  endtask

  task automatic add_typed(input int vi, input int x, input int y, input int z, input bit d);
    mesh_cmd_t c;
    c = mk_cmd(ACT_READ, vi, 0, 0, 0, 0, 0, 0, 0, 3);
    c.typed = 1'b1;
    c.ex = 16'(x); c.ey = 16'(y); c.ez = 16'(z); c.edeg = d;
    add_row(c);
  endtask

  task automatic random_phase(input int count, input int read_pct);
    mesh_cmd_t c;
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        c = noise_cmd(ACT_LOAD);
      end else if (r < 10 + read_pct) begin
        c = noise_cmd(ACT_READ);
        c.vidx = 10'(pick_loaded());
      end else if (r < 95) begin
        c = noise_cmd(ACT_FACE);
        c.ca = 10'(pick_loaded()); c.cb = 10'(pick_loaded());
        c.cc = 10'(pick_loaded()); c.cd = 10'(pick_loaded());
        // mostly well-formed counts, some odd ones taken as triangles
        if ($urandom_range(0, 9) != 0) c.cnt = $urandom_range(0, 1) ? 3'd4 : 3'd3;
      end else begin
        c = noise_cmd(ACT_NONE);
      end
      send_cmd(c);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    normal_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_normals.size() == 0) begin
        $error("unexpected result transaction");
        mismatches++;
      end else begin
        e = pending_normals.pop_front();
        if (out_normal_x !== e.x) begin
          $error("normal_x expected %0d got %0d", e.x, out_normal_x); mismatches++;
        end
        if (out_normal_y !== e.y) begin
          $error("normal_y expected %0d got %0d", e.y, out_normal_y); mismatches++;
        end
        if (out_normal_z !== e.z) begin
          $error("normal_z expected %0d got %0d", e.z, out_normal_z); mismatches++;
        end
        if (out_degenerate !== e.deg) begin
          $error("degenerate expected %0d got %0d", e.deg, out_degenerate); mismatches++;
        end
      end
    end
  end

  // receiver: random stall bursts plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIM) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    mesh_cmd_t c;
    rst_n = 1'b0;
    flip_q = 1'b1;
    for (int i = 0; i < NV; i++) loaded[i] = 1'b0;

    add_row(mk_cmd(ACT_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 3));
    add_row(mk_cmd(ACT_LOAD, 1023, 32767, 32767, 32767, 0, 0, 0, 0, 3));
    add_row(mk_cmd(ACT_LOAD, 512, -32768, -32768, -32768, 0, 0, 0, 0, 3));
    add_typed(0, 0, 0, 0, 1'b1);          // fresh sum: zero, flip keeps zero
    add_row(mk_cmd(ACT_LOAD, 1, 0, 0, 0, 0, 0, 0, 0, 3));
    add_row(mk_cmd(ACT_LOAD, 2, 100, 0, 0, 0, 0, 0, 0, 3));
    add_row(mk_cmd(ACT_LOAD, 3, 0, 100, 0, 0, 0, 0, 0, 3));
    add_row(mk_cmd(ACT_FACE, 0, 0, 0, 0, 1, 2, 3, 0, 3));
    add_typed(1, 0, 0, 16384, 1'b0);      // face normal -z, flipped
    add_row(mk_cmd(ACT_NONE, 1, 5, 5, 5, 1, 2, 3, 3, 4));
    add_row(mk_cmd(ACT_FACE, 0, 0, 0, 0, 0, 1023, 512, 0, 3));
    add_typed(1023, 0, 0, 0, 1'b1);       // collinear corners add zero
    add_row(mk_cmd(ACT_LOAD, 4, 100, 100, 0, 0, 0, 0, 0, 3));
    add_row(mk_cmd(ACT_FACE, 0, 0, 0, 0, 1, 2, 4, 3, 4));
    add_row(mk_cmd(ACT_FACE, 0, 0, 0, 0, 2, 3, 1, 4, 7));
    add_row(mk_cmd(ACT_FACE, 0, 0, 0, 0, 1, 2, 3, 3, 4));
    add_row(mk_cmd(ACT_LOAD, 5, 32767, -32768, 0, 0, 0, 0, 0, 3));
    add_row(mk_cmd(ACT_FACE, 0, 0, 0, 0, 512, 1023, 5, 0, 0));
    add_row(mk_cmd(ACT_READ, 2, 0, 0, 0, 0, 0, 0, 0, 3));
    add_row(mk_cmd(ACT_READ, 3, 0, 0, 0, 0, 0, 0, 0, 3));
    add_row(mk_cmd(ACT_READ, 5, 0, 0, 0, 0, 0, 0, 0, 3));
    add_row(mk_cmd(ACT_READ, 512, 0, 0, 0, 0, 0, 0, 0, 3));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_cmd(dir_rows[i]);
    drain_and_idle();

    // saturation: vertex 3 appears twice per quad and clips first
    write_flip(1'b0);
    for (int k = 0; k < 300; k++) begin
      send_cmd(mk_cmd(ACT_FACE, 0, 0, 0, 0, 1, 2, 3, 3, 4));
      if (k % 50 == 49) send_cmd(mk_cmd(ACT_READ, 3, 0, 0, 0, 0, 0, 0, 0, 3));
    end
    drain_and_idle();

    for (int ph = 0; ph < 8; ph++) begin
      write_flip(ph[0]);
      if (ph == 1) hold_req = 1'b1;  // long receiver stall under read-heavy traffic
      if (ph == 7) calm = 1'b1;
      random_phase(150, (ph == 1) ? 60 : 25);
      drain_and_idle();
    end

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/mvna_pkg.sv
rtl/core/mvna_front.sv
rtl/core/mvna_queue.sv
rtl/core/mvna_norm.sv
rtl/core/mvna_back.sv
rtl/core/mesh_vertex_normal_accumulator.sv
verif/mesh_vertex_normal_accumulator_test.sv
